FILE: src/gwps_pkg.sv
// ----------------------------------------------------------------------------
// gwps_pkg: shared types and constants for the grid word path search
// Sizes of the grid and word stores, opcodes, direction codes and the
// structs passed between the top level and the search engine.
// ----------------------------------------------------------------------------
package gwps_pkg;

    localparam int MAX_ROWS = 16;
    localparam int MAX_COLS = 16;
    localparam int MAX_WORD = 16;
    localparam int CELLS    = MAX_ROWS * MAX_COLS;

    localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CELL_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int DEPTH_W = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

    // field widths fixed by the item format
    localparam int DIM_W    = 5;
    localparam int LETTER_W = 8;
    localparam int FPOS_W   = 4;
    localparam int DIR_W    = 3;

    typedef enum logic [1:0] {
        OP_GRID   = 2'd0,
        OP_WORD   = 2'd1,
        OP_SEARCH = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        CFG_ROWS = 2'd0,
        CFG_COLS = 2'd1,
        CFG_LEN  = 2'd2
    } t_cfg_idx;

    // neighbor order: down, right, left, up; DIR_END means all tried
    localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_UP    = 3'd3;
    localparam logic [DIR_W-1:0] DIR_END   = 3'd4;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_cell;

    // command from the input side, valid for one cycle
    typedef struct packed {
        logic                start;
        logic                load_grid;
        logic                load_word;
        logic [FPOS_W-1:0]   row;
        logic [FPOS_W-1:0]   col;
        logic [FPOS_W-1:0]   pos;
        logic [LETTER_W-1:0] letter;
    } t_cmd;

    // saturated limits of the grid and word in use
    typedef struct packed {
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
        logic [DIM_W-1:0] len;
    } t_lim;

    typedef struct packed {
        logic idle;
        logic done;
        logic found;
    } t_stat;

    function automatic logic [CELL_W-1:0] cell_addr(input t_cell c);
        return CELL_W'(int'(c.row) * MAX_COLS + int'(c.col));
    endfunction

endpackage

FILE: src/gwps_engine.sv
// ----------------------------------------------------------------------------
// gwps_engine: stores and backtracking search sequencer
// Holds the grid memory, the word letters and the path stack, and walks
// start cells and neighbors one step per cycle. A cell counts as used while
// it sits on the path stack.
// ----------------------------------------------------------------------------
module gwps_engine
    import gwps_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  t_lim  i_lim,
    input  logic  i_res_take,
    output t_stat o_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_TRY,
        S_CMP,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    logic [LETTER_W-1:0] r_grid [CELLS];
    logic [LETTER_W-1:0] r_word [MAX_WORD];
    logic [LETTER_W-1:0] r_rd_data;
    logic [CELL_W-1:0]   rd_addr;

    t_cell               r_cell_stk [MAX_WORD];
    logic [DIR_W-1:0]    r_dir_stk  [MAX_WORD];

    logic [ROW_W-1:0]    r_srow, n_srow;
    logic [COL_W-1:0]    r_scol, n_scol;
    logic [DEPTH_W-1:0]  r_depth, n_depth;
    t_cell               r_next, n_next;
    logic                r_found, n_found;

    logic                stk_start, dir_inc, push;
    t_cell               scan_cell, cur, nb;
    logic [DIR_W-1:0]    dir;
    logic                nb_ok;
    logic                nb_seen;
    logic                last_start;
    logic [ROW_W-1:0]    adv_row;
    logic [COL_W-1:0]    adv_col;
    logic [DEPTH_W-1:0]  depth_up;

    assign scan_cell = '{row: r_srow, col: r_scol};
    assign cur       = r_cell_stk[r_depth];
    assign dir       = r_dir_stk[r_depth];
    assign depth_up  = r_depth + DEPTH_W'(1);

    // next start cell in row-major order
    always_comb begin
        adv_row    = r_srow;
        adv_col    = r_scol + COL_W'(1);
        last_start = 1'b0;
        if (DIM_W'(r_scol) + DIM_W'(1) >= i_lim.cols) begin
            adv_col = '0;
            adv_row = r_srow + ROW_W'(1);
            if (DIM_W'(r_srow) + DIM_W'(1) >= i_lim.rows) begin
                last_start = 1'b1;
            end
        end
    end

    // neighbor of the top-of-stack cell in the current direction
    always_comb begin
        nb    = cur;
        nb_ok = 1'b0;
        unique case (dir)
            DIR_DOWN: begin
                nb_ok  = (DIM_W'(cur.row) + DIM_W'(1) < i_lim.rows);
                nb.row = cur.row + ROW_W'(1);
            end
            DIR_RIGHT: begin
                nb_ok  = (DIM_W'(cur.col) + DIM_W'(1) < i_lim.cols);
                nb.col = cur.col + COL_W'(1);
            end
            DIR_LEFT: begin
                nb_ok  = (cur.col != '0);
                nb.col = cur.col - COL_W'(1);
            end
            DIR_UP: begin
                nb_ok  = (cur.row != '0);
                nb.row = cur.row - ROW_W'(1);
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

    // neighbor already used if it sits on the path up to the current depth
    always_comb begin
        nb_seen = 1'b0;
        for (int k = 0; k < MAX_WORD; k++) begin
            if (DEPTH_W'(k) <= r_depth && r_cell_stk[k] == nb) begin
                nb_seen = 1'b1;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_srow    = r_srow;
        n_scol    = r_scol;
        n_depth   = r_depth;
        n_next    = r_next;
        n_found   = r_found;
        stk_start = 1'b0;
        dir_inc   = 1'b0;
        push      = 1'b0;
        rd_addr   = cell_addr(scan_cell);
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.start) begin
                    n_found = 1'b0;
                    n_srow  = '0;
                    n_scol  = '0;
                    if (i_lim.len == '0 || i_lim.rows == '0 || i_lim.cols == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                rd_addr = cell_addr(scan_cell);
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (r_rd_data == r_word[0]) begin
                    stk_start = 1'b1;
                    n_depth   = '0;
                    n_state   = S_TRY;
                end else if (last_start) begin
                    n_state = S_DONE;
                end else begin
                    n_srow  = adv_row;
                    n_scol  = adv_col;
                    n_state = S_SCAN_RD;
                end
            end
            S_TRY: begin
                if (DIM_W'(r_depth) + DIM_W'(1) >= i_lim.len) begin
                    n_found = 1'b1;
                    n_state = S_DONE;
                end else if (dir == DIR_END) begin
                    if (r_depth == '0) begin
                        if (last_start) begin
                            n_state = S_DONE;
                        end else begin
                            n_srow  = adv_row;
                            n_scol  = adv_col;
                            n_state = S_SCAN_RD;
                        end
                    end else begin
                        n_depth = r_depth - DEPTH_W'(1);
                    end
                end else begin
                    dir_inc = 1'b1;
                    rd_addr = cell_addr(nb);
                    if (nb_ok && !nb_seen) begin
                        n_next  = nb;
                        n_state = S_CMP;
                    end
                end
            end
            S_CMP: begin
                if (r_rd_data == r_word[depth_up]) begin
                    push    = 1'b1;
                    n_depth = depth_up;
                end
                n_state = S_TRY;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_srow  <= n_srow;
        r_scol  <= n_scol;
        r_depth <= n_depth;
        r_next  <= n_next;
    end

    // grid memory: one write port for loads, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_grid) begin
            r_grid[cell_addr('{row: ROW_W'(i_cmd.row), col: COL_W'(i_cmd.col)})]
                <= i_cmd.letter;
        end
        r_rd_data <= r_grid[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_word) begin
            r_word[DEPTH_W'(i_cmd.pos)] <= i_cmd.letter;
        end
    end

    // path stack
    always_ff @(posedge i_clk) begin
        if (stk_start) begin
            r_cell_stk[0] <= scan_cell;
            r_dir_stk[0]  <= DIR_DOWN;
        end
        if (dir_inc) begin
            r_dir_stk[r_depth] <= dir + DIR_W'(1);
        end
        if (push) begin
            r_cell_stk[depth_up] <= r_next;
            r_dir_stk[depth_up]  <= DIR_DOWN;
        end
    end

    assign o_stat.idle  = (r_state == S_IDLE);
    assign o_stat.done  = (r_state == S_DONE);
    assign o_stat.found = r_found;

endmodule

FILE: src/grid_word_path_search_top.sv
// ----------------------------------------------------------------------------
// grid_word_path_search_top: word path search over a letter grid
// Loads letters into a grid and a word, then traces the word through
// 4-neighbor adjacent cells by depth-first backtracking.
// ----------------------------------------------------------------------------
//
//  channel   dir   beats/item   contents
//  s_axis    in    1            opcode, row, col, word_pos, letter
//  m_axis    out   1            found (one transfer per search item)
//  i_cfg_*   in    1            grid_rows, grid_cols, word_length
//
//  A search scans each start cell (a grid read, then a compare), tries
//  neighbors in turn (a valid, unused candidate is read and then
//  compared), backtracks when all directions are tried, stops on a hit, and
//  in the done state hands the result to the output register; all grid
//  reads run through the single read port of the grid memory.
//  s_axis_tready is low while a search runs. A finished result sits in the
//  output register; a further search completes but holds its result until
//  that register is free. Reset (synchronous, active low) clears control
//  state and sets the registers to 16 x 16 with an empty word; a cell counts
//  as used only while it is on the path stack, so nothing is left to clear.
//
module grid_word_path_search_top
    import gwps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] opcode, [5:2] row, [9:6] col, [13:10] word_pos, [21:14] letter,
    // [23:22] zero
    input  logic [23:0] s_axis_tdata,
    // stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] found, [7:1] zero
    output logic [7:0]  m_axis_tdata,
    // register writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [4:0]  i_cfg_data
);

    logic [DIM_W-1:0] r_grid_rows;
    logic [DIM_W-1:0] r_grid_cols;
    logic [DIM_W-1:0] r_word_len;

    logic    r_out_valid;
    logic    r_out_found;

    t_cmd    cmd;
    t_lim    lim;
    t_stat   stat;
    t_opcode opcode;
    logic    in_xfer;
    logic    res_take;

    // register writes; out-of-range indices fall through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= DIM_W'(MAX_ROWS);
            r_grid_cols <= DIM_W'(MAX_COLS);
            r_word_len  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROWS: r_grid_rows <= i_cfg_data;
                CFG_COLS: r_grid_cols <= i_cfg_data;
                CFG_LEN:  r_word_len  <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // oversized settings clamp to the store sizes
    assign lim.rows = (r_grid_rows > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : r_grid_rows;
    assign lim.cols = (r_grid_cols > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : r_grid_cols;
    assign lim.len  = (r_word_len  > DIM_W'(MAX_WORD)) ? DIM_W'(MAX_WORD) : r_word_len;

    // input transfers; opcode 3 is taken and dropped
    assign s_axis_tready = stat.idle;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign opcode        = t_opcode'(s_axis_tdata[1:0]);

    assign cmd.start     = in_xfer && (opcode == OP_SEARCH);
    assign cmd.load_grid = in_xfer && (opcode == OP_GRID)
                           && (int'(s_axis_tdata[5:2]) < MAX_ROWS)
                           && (int'(s_axis_tdata[9:6]) < MAX_COLS);
    assign cmd.load_word = in_xfer && (opcode == OP_WORD)
                           && (int'(s_axis_tdata[13:10]) < MAX_WORD);
    assign cmd.row       = s_axis_tdata[5:2];
    assign cmd.col       = s_axis_tdata[9:6];
    assign cmd.pos       = s_axis_tdata[13:10];
    assign cmd.letter    = s_axis_tdata[21:14];

    gwps_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_lim      (lim),
        .i_res_take (res_take),
        .o_stat     (stat)
    );

    // output register: takes a result when empty or being drained
    assign res_take = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stat.done && res_take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stat.done && res_take) begin
            r_out_found <= stat.found;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_found};

endmodule

FILE: tb/sv/grid_word_path_search_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_word_path_search_top_tb: self-checking bench for the word path search
// Loads letters into the grid and word stores and runs searches under
// changing grid sizes and word lengths. Starts with a short directed table,
// then mostly planted words traced along random walks. Every found transfer
// is checked against a search model kept in the bench, with random stalls
// on both streams.
// ----------------------------------------------------------------------------
module grid_word_path_search_top_tb;
    import gwps_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 11;
    // input items over the whole run, store fill included
    localparam int TOTAL_ITEMS  = 650;
    // this covers a load that is still in flight
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 32;
    // receiver hold-off that backs the block up into its input
    localparam int HOLD_CYCLES   = 500;
    // run limit with room for 16x16 scans, backtracking walks and long stalls
    // on both sides
    localparam int TIMEOUT_NS    = 40_000_000;

    // opcode and register index left unused by the block
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [1:0] CFG_SPARE = 2'd3;

    // the 4x4 corner gets a 3-letter alphabet so that long paths are common;
    // the rest of the grid uses 10 letters to keep failing searches short
    localparam logic [7:0] LETTER_BASE = 8'h41;
    localparam int         NARROW_SPAN = 3;
    localparam int         WIDE_SPAN   = 10;
    localparam int         CORNER      = 4;

    // one stream transfer; opcode sits in the lowest bits
    typedef struct packed {
        logic [1:0]          pad;
        logic [LETTER_W-1:0] letter;
        logic [FPOS_W-1:0]   word_pos;
        logic [FPOS_W-1:0]   col;
        logic [FPOS_W-1:0]   row;
        logic [1:0]          opcode;
    } t_item;

    typedef enum logic [1:0] {STEP_ITEM, STEP_CFG, STEP_FILL} t_plan_kind;

    // directed row: code is an opcode or a register index, value a letter
    // or register data; typed rows carry their own expected found bit
    typedef struct {
        t_plan_kind          kind;
        logic [1:0]          code;
        logic [FPOS_W-1:0]   row;
        logic [FPOS_W-1:0]   col;
        logic [FPOS_W-1:0]   pos;
        logic [LETTER_W-1:0] value;
        bit                  typed;
        bit                  want;
    } t_plan_row;

    localparam int PLAN_ROWS = 30;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;    // [1:0] opcode, [5:2] row, [9:6] col,
                                  // [13:10] word_pos, [21:14] letter
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;    // [0] found
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [4:0]  i_cfg_data;

    // bench copy of the block's stores and registers
    logic [LETTER_W-1:0] grid_copy [CELLS];
    logic [LETTER_W-1:0] word_copy [MAX_WORD];
    logic [DIM_W-1:0]    rows_reg;
    logic [DIM_W-1:0]    cols_reg;
    logic [DIM_W-1:0]    len_reg;

    bit        found_due [$];     // expected found bits, oldest first
    int        fail_count;
    int        items_sent;
    bit        hold_req;
    bit        hold_active;
    bit        calm_mode;         // phase with no idling on either side
    t_plan_row directed_plan [PLAN_ROWS];

    grid_word_path_search_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int clip(logic [DIM_W-1:0] v, int hi);
        return (int'(v) > hi) ? hi : int'(v);
    endfunction

    function automatic int idle_gap();
        int roll;
        if (calm_mode) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] narrow_letter();
        return LETTER_BASE + 8'($urandom_range(0, NARROW_SPAN - 1));
    endfunction

    function automatic logic [7:0] letter_for(int r, int c);
        if (r < CORNER && c < CORNER) return narrow_letter();
        return LETTER_BASE + 8'($urandom_range(0, WIDE_SPAN - 1));
    endfunction

    function automatic t_item make_item(logic [1:0] op, logic [3:0] r, logic [3:0] c,
                                        logic [3:0] p, logic [7:0] ch);
        t_item it;
        it = '0;
        it.opcode   = op;
        it.row      = r;
        it.col      = c;
        it.word_pos = p;
        it.letter   = ch;
        return it;
    endfunction

    // Is the word a path of 4-neighbor cells, no cell used twice?
    // Depth-first with an explicit stack; neighbors down, right, left, up.
    function automatic bit word_traceable();
        int               n_rows, n_cols, n_len;
        int               here, there, depth, r, c;
        logic [DIR_W-1:0] dir;
        bit               ok;
        bit               seen [CELLS];
        int               trail [MAX_WORD];
        logic [DIR_W-1:0] next_dir [MAX_WORD];
        n_rows = clip(rows_reg, MAX_ROWS);
        n_cols = clip(cols_reg, MAX_COLS);
        n_len  = clip(len_reg, MAX_WORD);
        if (n_len == 0) return 1'b0;
        for (int sr = 0; sr < n_rows; sr++) begin
            for (int sc = 0; sc < n_cols; sc++) begin
                here = sr * MAX_COLS + sc;
                if (grid_copy[here] != word_copy[0]) continue;
                if (n_len == 1) return 1'b1;
                seen = '{default: 1'b0};
                depth = 0;
                trail[0] = here;
                next_dir[0] = DIR_DOWN;
                seen[here] = 1'b1;
                while (depth >= 0) begin
                    if (next_dir[depth] == DIR_END) begin
                        seen[trail[depth]] = 1'b0;
                        depth--;
                    end else begin
                        dir = next_dir[depth];
                        next_dir[depth] = dir + 3'd1;
                        r = trail[depth] / MAX_COLS;
                        c = trail[depth] % MAX_COLS;
                        ok = 1'b1;
                        case (dir)
                            DIR_DOWN:  if (r + 1 < n_rows) r++; else ok = 1'b0;
                            DIR_RIGHT: if (c + 1 < n_cols) c++; else ok = 1'b0;
                            DIR_LEFT:  if (c > 0) c--; else ok = 1'b0;
                            default:   if (r > 0) r--; else ok = 1'b0;
                        endcase
                        there = r * MAX_COLS + c;
                        if (ok && !seen[there] && grid_copy[there] == word_copy[depth + 1]) begin
                            depth++;
                            trail[depth] = there;
                            next_dir[depth] = DIR_DOWN;
                            seen[there] = 1'b1;
                            if (depth + 1 >= n_len) return 1'b1;
                        end
                    end
                end
            end
        end
        return 1'b0;
    endfunction

    // Offer one item; valid stays high after the transfer so that a
    // back-to-back item follows without a bubble. preset < 0 means the
    // expected found bit comes from the search model.
    task automatic send_item(t_item it, bit no_gap, int preset);
        int gap;
        gap = no_gap ? 0 : idle_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it;
        do @(posedge i_clk); while (!s_axis_tready);
        case (it.opcode)
            OP_GRID:   grid_copy[int'(it.row) * MAX_COLS + int'(it.col)] = it.letter;
            OP_WORD:   word_copy[it.word_pos] = it.letter;
            OP_SEARCH: found_due.insert(found_due.size(),
                                        preset < 0 ? word_traceable() : preset[0]);
            default:   ;
        endcase
        items_sent++;
    endtask

    // Drop valid, let every expected result arrive, then let loads settle.
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (found_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [DIM_W-1:0] val);
        wait_quiet();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_ROWS: rows_reg = val;
            CFG_COLS: cols_reg = val;
            CFG_LEN:  len_reg  = val;
            default:  ;
        endcase
    endtask

    // Every store entry gets written once so no search reads an unwritten one.
    task automatic fill_stores();
        for (int r = 0; r < MAX_ROWS; r++)
            for (int c = 0; c < MAX_COLS; c++)
                send_item(make_item(OP_GRID, 4'(r), 4'(c), 4'd0, letter_for(r, c)), 1'b0, -1);
        for (int p = 0; p < MAX_WORD; p++)
            send_item(make_item(OP_WORD, 4'd0, 4'd0, 4'(p), narrow_letter()), 1'b0, -1);
    endtask

    task automatic send_search();
        send_item(make_item(OP_SEARCH, 4'($urandom), 4'($urandom), 4'($urandom),
                            8'($urandom)), 1'b0, -1);
    endtask

    // Copy the letters of a random self-avoiding walk into the word, so the
    // search usually hits; a walk that gets stuck leaves a random tail.
    task automatic plant_word();
        int         n_rows, n_cols, n_len, steps, r, c, spot, n_opts;
        int         trail [MAX_WORD];
        int         opts [4];
        bit         taken [CELLS];
        logic [7:0] ch;
        n_rows = clip(rows_reg, MAX_ROWS);
        n_cols = clip(cols_reg, MAX_COLS);
        n_len  = clip(len_reg, MAX_WORD);
        if (n_len > 0 && n_rows > 0 && n_cols > 0) begin
            taken = '{default: 1'b0};
            trail[0] = $urandom_range(0, n_rows - 1) * MAX_COLS
                     + $urandom_range(0, n_cols - 1);
            taken[trail[0]] = 1'b1;
            steps = 1;
            while (steps < n_len) begin
                spot = trail[steps - 1];
                r = spot / MAX_COLS;
                c = spot % MAX_COLS;
                n_opts = 0;
                if (r + 1 < n_rows && !taken[spot + MAX_COLS]) begin
                    opts[n_opts] = spot + MAX_COLS;
                    n_opts++;
                end
                if (c + 1 < n_cols && !taken[spot + 1]) begin
                    opts[n_opts] = spot + 1;
                    n_opts++;
                end
                if (c > 0 && !taken[spot - 1]) begin
                    opts[n_opts] = spot - 1;
                    n_opts++;
                end
                if (r > 0 && !taken[spot - MAX_COLS]) begin
                    opts[n_opts] = spot - MAX_COLS;
                    n_opts++;
                end
                if (n_opts == 0) break;
                spot = opts[$urandom_range(0, n_opts - 1)];
                trail[steps] = spot;
                taken[spot] = 1'b1;
                steps++;
            end
            for (int k = 0; k < n_len; k++) begin
                ch = (k < steps) ? grid_copy[trail[k]] : narrow_letter();
                send_item(make_item(OP_WORD, 4'($urandom), 4'($urandom), 4'(k), ch),
                          1'b0, -1);
            end
        end
        send_search();
    endtask

    task automatic random_word();
        int  n_len;
        bit  narrow;
        n_len  = clip(len_reg, MAX_WORD);
        narrow = clip(rows_reg, MAX_ROWS) <= CORNER && clip(cols_reg, MAX_COLS) <= CORNER;
        for (int k = 0; k < n_len; k++)
            send_item(make_item(OP_WORD, 4'd0, 4'd0, 4'(k),
                                narrow ? narrow_letter() : letter_for(CORNER, CORNER)),
                      1'b0, -1);
        send_search();
    endtask

    // Noise: grid writes anywhere, full-range letters, writes past the word
    // and the unused opcode, then maybe a search.
    task automatic shake_grid();
        int         r, c, n_len;
        logic [7:0] ch;
        repeat ($urandom_range(1, 4)) begin
            r = $urandom_range(0, MAX_ROWS - 1);
            c = $urandom_range(0, MAX_COLS - 1);
            ch = ($urandom_range(0, 3) == 0) ? 8'($urandom) : letter_for(r, c);
            send_item(make_item(OP_GRID, 4'(r), 4'(c), 4'($urandom), ch), 1'b0, -1);
        end
        n_len = clip(len_reg, MAX_WORD);
        if (n_len < MAX_WORD && $urandom_range(0, 1) == 0)
            send_item(make_item(OP_WORD, 4'd0, 4'd0,
                                4'($urandom_range(n_len, MAX_WORD - 1)), 8'($urandom)),
                      1'b0, -1);
        if ($urandom_range(0, 2) == 0)
            send_item(make_item(OP_UNUSED, 4'($urandom), 4'($urandom), 4'($urandom),
                                8'($urandom)), 1'b0, -1);
        if ($urandom_range(0, 1) == 0) send_search();
    endtask

    // Every found transfer is matched against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (found_due.size() == 0) begin
                $error("found: no result expected, got %0b", m_axis_tdata[0]);
                fail_count++;
            end else begin
                if (m_axis_tdata[0] !== found_due[0]) begin
                    $error("found: expected %0b, got %0b", found_due[0], m_axis_tdata[0]);
                    fail_count++;
                end
                found_due.delete(0);
            end
        end
    end

    // Receiver: random ready stretches and gaps, plus one long hold-off on
    // request so results pile up and the input side stalls.
    initial begin
        int gap;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                hold_active = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_active = 1'b0;
                hold_req    = 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
                gap = idle_gap();
                if (gap > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int shape, n_rows, n_cols, n_len, roll;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_ROWS;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        rows_reg = DIM_W'(MAX_ROWS);
        cols_reg = DIM_W'(MAX_COLS);
        len_reg  = '0;
        fail_count  = 0;
        items_sent  = 0;
        hold_req    = 1'b0;
        hold_active = 1'b0;
        calm_mode   = 1'b0;

        // Directed table. Rows before the fill read no store entry.
        directed_plan = '{
            // empty word right after reset
            '{STEP_ITEM, OP_SEARCH, 4'd0,  4'd0,  4'd0,  8'h00, 1'b1, 1'b0},
            // unused opcode at the field extremes: no result, no write
            '{STEP_ITEM, OP_UNUSED, 4'd15, 4'd15, 4'd15, 8'hFF, 1'b0, 1'b0},
            '{STEP_FILL, OP_GRID,   4'd0,  4'd0,  4'd0,  8'h00, 1'b0, 1'b0},
            // 1x1 grid, one-letter word
            '{STEP_CFG,  CFG_ROWS,  4'd0,  4'd0,  4'd0,  8'd1,  1'b0, 1'b0},
            '{STEP_CFG,  CFG_COLS,  4'd0,  4'd0,  4'd0,  8'd1,  1'b0, 1'b0},
            '{STEP_CFG,  CFG_LEN,   4'd0,  4'd0,  4'd0,  8'd1,  1'b0, 1'b0},
            '{STEP_ITEM, OP_GRID,   4'd0,  4'd0,  4'd0,  8'h00, 1'b0, 1'b0},
            '{STEP_ITEM, OP_WORD,   4'd0,  4'd0,  4'd0,  8'h00, 1'b0, 1'b0},
            '{STEP_ITEM, OP_SEARCH, 4'd0,  4'd0,  4'd0,  8'h00, 1'b1, 1'b1},
            '{STEP_ITEM, OP_GRID,   4'd0,  4'd0,  4'd0,  8'hFF, 1'b0, 1'b0},
            '{STEP_ITEM, OP_SEARCH, 4'd0,  4'd0,  4'd0,  8'h00, 1'b1, 1'b0},
            '{STEP_ITEM, OP_WORD,   4'd0,  4'd0,  4'd0,  8'hFF, 1'b0, 1'b0},
            '{STEP_ITEM, OP_SEARCH, 4'd0,  4'd0,  4'd0,  8'h00, 1'b1, 1'b1},
            // two letters cannot fit in one cell
            '{STEP_CFG,  CFG_LEN,   4'd0,  4'd0,  4'd0,  8'd2,  1'b0, 1'b0},
            '{STEP_ITEM, OP_SEARCH, 4'd0,  4'd0,  4'd0,  8'h00, 1'b1, 1'b0},
            // zero rows, then zero columns: no cells at all
            '{STEP_CFG,  CFG_ROWS,  4'd0,  4'd0,  4'd0,  8'd0,  1'b0, 1'b0},
            '{STEP_ITEM, OP_SEARCH, 4'd0,  4'd0,  4'd0,  8'h00, 1'b1, 1'b0},
            '{STEP_CFG,  CFG_ROWS,  4'd0,  4'd0,  4'd0,  8'd16, 1'b0, 1'b0},
            '{STEP_CFG,  CFG_COLS,  4'd0,  4'd0,  4'd0,  8'd0,  1'b0, 1'b0},
            '{STEP_ITEM, OP_SEARCH, 4'd0,  4'd0,  4'd0,  8'h00, 1'b1, 1'b0},
            // oversized registers saturate to the full grid and word
            '{STEP_CFG,  CFG_ROWS,  4'd0,  4'd0,  4'd0,  8'd31, 1'b0, 1'b0},
            '{STEP_CFG,  CFG_COLS,  4'd0,  4'd0,  4'd0,  8'd31, 1'b0, 1'b0},
            '{STEP_CFG,  CFG_LEN,   4'd0,  4'd0,  4'd0,  8'd31, 1'b0, 1'b0},
            '{STEP_ITEM, OP_GRID,   4'd15, 4'd15, 4'd0,  8'hA5, 1'b0, 1'b0},
            '{STEP_ITEM, OP_WORD,   4'd0,  4'd0,  4'd15, 8'h5A, 1'b0, 1'b0},
            '{STEP_ITEM, OP_SEARCH, 4'd0,  4'd0,  4'd0,  8'h00, 1'b0, 1'b0},
            // register index past the last one is dropped
            '{STEP_CFG,  CFG_SPARE, 4'd0,  4'd0,  4'd0,  8'h1F, 1'b0, 1'b0},
            '{STEP_ITEM, OP_SEARCH, 4'd0,  4'd0,  4'd0,  8'h00, 1'b0, 1'b0},
            '{STEP_CFG,  CFG_LEN,   4'd0,  4'd0,  4'd0,  8'd0,  1'b0, 1'b0},
            '{STEP_ITEM, OP_SEARCH, 4'd0,  4'd0,  4'd0,  8'h00, 1'b1, 1'b0}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[i]) begin
            case (directed_plan[i].kind)
                STEP_FILL: fill_stores();
                STEP_CFG:  write_reg(directed_plan[i].code, directed_plan[i].value[4:0]);
                default:
                    send_item(make_item(directed_plan[i].code, directed_plan[i].row,
                                        directed_plan[i].col, directed_plan[i].pos,
                                        directed_plan[i].value),
                              1'b0,
                              directed_plan[i].typed ? int'(directed_plan[i].want) : -1);
            endcase
        end

        // Back-pressure: searches offered back to back while the receiver
        // holds off, so the output register fills and the input stalls.
        write_reg(CFG_ROWS, 5'd2);
        write_reg(CFG_COLS, 5'd2);
        write_reg(CFG_LEN, 5'd1);
        hold_req = 1'b1;
        while (!hold_active) @(posedge i_clk);
        repeat (8) send_item(make_item(OP_SEARCH, 4'd0, 4'd0, 4'd0, 8'h00), 1'b1, -1);

        // Random phases: a register setting, then a run of sequences.
        // Most phases use grids inside the dense corner.
        while (items_sent < TOTAL_ITEMS) begin
            calm_mode = ($urandom_range(0, 4) == 0);
            shape = $urandom_range(0, 9);
            if (shape == 0) begin
                case ($urandom_range(0, 3))
                    0: begin n_rows = 16; n_cols = 16; end
                    1: begin n_rows = 31; n_cols = 31; end
                    2: begin n_rows = 1;  n_cols = 16; end
                    default: begin n_rows = 16; n_cols = 1; end
                endcase
            end else if (shape == 1) begin
                n_rows = $urandom_range(1, MAX_ROWS);
                n_cols = $urandom_range(1, MAX_COLS);
            end else begin
                n_rows = $urandom_range(1, CORNER);
                n_cols = $urandom_range(1, CORNER);
            end
            roll = $urandom_range(0, 19);
            if (roll == 0)      n_len = 0;
            else if (roll == 1) n_len = MAX_WORD;
            else if (roll == 2) n_len = $urandom_range(MAX_WORD + 1, 31);
            else                n_len = $urandom_range(1, 6);
            write_reg(CFG_ROWS, 5'(n_rows));
            write_reg(CFG_COLS, 5'(n_cols));
            write_reg(CFG_LEN, 5'(n_len));
            if ($urandom_range(0, 7) == 0) write_reg(CFG_SPARE, 5'($urandom));
            repeat ($urandom_range(3, 8)) begin
                roll = $urandom_range(0, 99);
                if (roll < 65)      plant_word();
                else if (roll < 82) random_word();
                else                shake_grid();
            end
        end

        wait_quiet();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
